// ===== sv/mwm_pkg.sv =====
// ----------------------------------------------------------------------------
// mwm_pkg
// Shared constants, types and codes for the maze wall map with odometry.
// ----------------------------------------------------------------------------
package mwm_pkg;

  localparam int GRID_ROWS = 16;
  localparam int GRID_COLS = 16;
  localparam int CELL_MM   = 180;

  localparam int TRAVEL_W   = 12;
  localparam int CELL_UNITS = CELL_MM * 16;
  localparam int HALF_UNITS = CELL_MM * 8;
  localparam int WIN_LO     = 89 * 16;
  localparam int WIN_HI     = 91 * 16;
  localparam int OFF_W      = $clog2(CELL_UNITS + (1 << TRAVEL_W));
  localparam int MAX_STEPS  = (CELL_UNITS + (1 << TRAVEL_W) - 1) / CELL_UNITS;
  localparam int STEP_W     = $clog2(MAX_STEPS + 1);

  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int SPOS_W = ((ROW_W > COL_W) ? ROW_W : COL_W) + 2;

  localparam int COL_DEPTH   = GRID_ROWS * (GRID_COLS - 1);
  localparam int ROW_DEPTH   = (GRID_ROWS - 1) * GRID_COLS;
  localparam int STORE_DEPTH = (COL_DEPTH > ROW_DEPTH) ? COL_DEPTH : ROW_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int WALL_W      = 8;

  localparam int GOAL_ROW = GRID_ROWS / 2 - 1;
  localparam int GOAL_COL = GRID_COLS / 2 - 1;

  localparam logic [2:0] MODE_WALL   = 3'd0;
  localparam logic [2:0] MODE_TURN   = 3'd1;
  localparam logic [2:0] MODE_SET    = 3'd2;
  localparam logic [2:0] MODE_TRAVEL = 3'd3;

  localparam logic [1:0] SIDE_RIGHT = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_NONE  = 2'd3;

  localparam logic [1:0] DIR_E = 2'd0;
  localparam logic [1:0] DIR_S = 2'd1;
  localparam logic [1:0] DIR_W = 2'd2;
  localparam logic [1:0] DIR_N = 2'd3;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [WALL_W-1:0] wall_t;
  typedef logic [ROW_W-1:0]         row_t;
  typedef logic [COL_W-1:0]         col_t;
  typedef logic [1:0]               dir_t;
  typedef logic [OFF_W-1:0]         off_t;
  typedef logic signed [SPOS_W-1:0] spos_t;

  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr0;
    addr_t rd_addr1;
    logic  wr_en;
    addr_t wr_addr;
    wall_t wr_data;
  } store_req_t;

  typedef struct packed {
    logic [3:0] row;
    logic [3:0] col;
    dir_t       heading;
    logic       open_right;
    logic       open_left;
    logic       in_goal;
  } result_t;

endpackage

// ===== sv/mwm_ram.sv =====
// ----------------------------------------------------------------------------
// mwm_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module mwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// ===== sv/mwm_wall_store.sv =====
// ----------------------------------------------------------------------------
// mwm_wall_store
// One wall confidence store: RAM, per-entry valid bits (unwritten reads as
// zero) and a bypass of the write made on the same edge as the read.
// ----------------------------------------------------------------------------
module mwm_wall_store (
  input  logic                clk,
  input  logic                rst_n,
  input  mwm_pkg::store_req_t req,
  output mwm_pkg::wall_t      rd_data0,
  output mwm_pkg::wall_t      rd_data1
);
  import mwm_pkg::*;

  logic [STORE_DEPTH-1:0] vld_r;
  logic [1:0]             rvld_r;
  addr_t                  raddr0_r;
  addr_t                  raddr1_r;
  logic                   wl_vld_r;
  addr_t                  wl_addr_r;
  wall_t                  wl_data_r;
  logic [WALL_W-1:0]      q0;
  logic [WALL_W-1:0]      q1;

  mwm_ram #(
    .WIDTH (WALL_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (req.wr_en),
    .waddr  (req.wr_addr),
    .wdata  (req.wr_data),
    .re     (req.rd_en),
    .raddr0 (req.rd_addr0),
    .raddr1 (req.rd_addr1),
    .rdata0 (q0),
    .rdata1 (q1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rvld_r   <= '0;
      wl_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rvld_r <= {vld_r[req.rd_addr1], vld_r[req.rd_addr0]};
      end
      wl_vld_r <= req.wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      raddr0_r <= req.rd_addr0;
      raddr1_r <= req.rd_addr1;
    end
    wl_addr_r <= req.wr_addr;
    wl_data_r <= req.wr_data;
  end

  // read-first RAM: a write on the read edge is forwarded
  always_comb begin
    if (wl_vld_r && (wl_addr_r == raddr0_r)) begin
      rd_data0 = wl_data_r;
    end else begin
      rd_data0 = rvld_r[0] ? wall_t'(q0) : '0;
    end
    if (wl_vld_r && (wl_addr_r == raddr1_r)) begin
      rd_data1 = wl_data_r;
    end else begin
      rd_data1 = rvld_r[1] ? wall_t'(q1) : '0;
    end
  end

endmodule

// ===== sv/maze_wall_map_odometry.sv =====
// ----------------------------------------------------------------------------
// maze_wall_map_odometry
// Wall confidence map of a maze grid plus pose tracking (cell, heading,
// distance into cell); one result transaction per input transaction.
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle while in_ready is high, and each yields exactly one result.
// The pose is updated on the accept edge; the two wall stores (horizontal and
// vertical edges) are read for all four sides of the new cell at that clock edge,
// and in the next cycle the selected wall is saturated, written back and the
// open flags are formed; the result is then written into the output buffer,
// whose count register raises out_valid. The read-modify-write on the wall
// RAMs uses a same-edge bypass.
// Results wait in a two-entry output buffer, so input stays ready while one
// result is stalled. Wall stores read as zero after reset through per-entry
// valid bits; no clearing pass is needed.
module maze_wall_map_odometry (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_mode,
  input  logic signed [7:0]     in_confidence,
  input  logic [1:0]            in_side,
  input  logic [1:0]            in_new_heading,
  input  logic [11:0]           in_travel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            out_row,
  output logic [3:0]            out_col,
  output logic [1:0]            out_heading,
  output logic                  out_open_right,
  output logic                  out_open_left,
  output logic                  out_in_goal
);
  import mwm_pkg::*;

  // pose
  row_t  row_r, row_nxt;
  col_t  col_r, col_nxt;
  dir_t  heading_r, heading_nxt;
  off_t  off_r, off_nxt;

  off_t              sum;
  off_t              rem;
  logic [STEP_W-1:0] nsteps;
  spos_t             srow;
  spos_t             scol;
  row_t              row_clamp;
  col_t              col_clamp;
  logic              win_ok;
  logic              accept;

  logic [3:0] ex;
  addr_t      ea [4];
  dir_t       udir;
  logic       upd;

  // stage 1
  logic       s1_valid_r;
  row_t       s1_row_r;
  col_t       s1_col_r;
  dir_t       s1_head_r;
  logic [3:0] s1_ex_r;
  addr_t      s1_addr_r [4];
  logic       s1_upd_r;
  dir_t       s1_udir_r;
  wall_t      s1_conf_r;

  store_req_t col_req;
  store_req_t row_req;
  wall_t      col_q0, col_q1, row_q0, row_q1;
  wall_t      ev [4];
  wall_t      after [4];
  logic signed [WALL_W:0] ssum;
  wall_t      new_val;
  dir_t       rdir;
  dir_t       ldir;
  result_t    res;

  // output buffer
  result_t    buf_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] occ;
  logic       pop;

  assign accept = in_valid && in_ready;
  assign win_ok = (off_r >= off_t'(WIN_LO)) && (off_r <= off_t'(WIN_HI));

  always_comb begin
    sum    = off_r + off_t'(in_travel);
    nsteps = '0;
    rem    = sum;
    for (int k = 1; k <= MAX_STEPS; k++) begin
      if (sum > off_t'(k * CELL_UNITS)) begin
        nsteps = STEP_W'(k);
        rem    = sum - off_t'(k * CELL_UNITS);
      end
    end
  end

  always_comb begin
    srow = spos_t'(row_r);
    scol = spos_t'(col_r);
    unique case (heading_r)
      DIR_E:   scol = scol + spos_t'(nsteps);
      DIR_S:   srow = srow + spos_t'(nsteps);
      DIR_W:   scol = scol - spos_t'(nsteps);
      default: srow = srow - spos_t'(nsteps);
    endcase
    priority if (srow < 0) begin
      row_clamp = '0;
    end else if (srow > spos_t'(GRID_ROWS - 1)) begin
      row_clamp = row_t'(GRID_ROWS - 1);
    end else begin
      row_clamp = row_t'(srow);
    end
    priority if (scol < 0) begin
      col_clamp = '0;
    end else if (scol > spos_t'(GRID_COLS - 1)) begin
      col_clamp = col_t'(GRID_COLS - 1);
    end else begin
      col_clamp = col_t'(scol);
    end
  end

  always_comb begin
    row_nxt     = row_r;
    col_nxt     = col_r;
    heading_nxt = heading_r;
    off_nxt     = off_r;
    unique case (in_mode)
      MODE_TURN: begin
        heading_nxt = heading_r + ((in_side == SIDE_RIGHT) ? 2'd1 : 2'd3);
        off_nxt     = off_t'(HALF_UNITS);
      end
      MODE_SET: begin
        heading_nxt = in_new_heading;
        off_nxt     = off_t'(HALF_UNITS);
      end
      MODE_TRAVEL: begin
        row_nxt = row_clamp;
        col_nxt = col_clamp;
        off_nxt = rem;
      end
      default: ;
    endcase
  end

  // edges of the cell after the step
  always_comb begin
    ex[DIR_E] = (col_nxt != col_t'(GRID_COLS - 1));
    ex[DIR_W] = (col_nxt != '0);
    ex[DIR_S] = (row_nxt != row_t'(GRID_ROWS - 1));
    ex[DIR_N] = (row_nxt != '0);
    ea[DIR_E] = ex[DIR_E] ?
                addr_t'(int'(row_nxt) * (GRID_COLS - 1) + int'(col_nxt)) : '0;
    ea[DIR_W] = ex[DIR_W] ?
                addr_t'(int'(row_nxt) * (GRID_COLS - 1) + int'(col_nxt) - 1) : '0;
    ea[DIR_S] = ex[DIR_S] ?
                addr_t'(int'(row_nxt) * GRID_COLS + int'(col_nxt)) : '0;
    ea[DIR_N] = ex[DIR_N] ?
                addr_t'((int'(row_nxt) - 1) * GRID_COLS + int'(col_nxt)) : '0;
  end

  always_comb begin
    priority if (in_side == SIDE_RIGHT) begin
      udir = heading_r + 2'd1;
    end else if (in_side == SIDE_LEFT) begin
      udir = heading_r + 2'd3;
    end else begin
      udir = heading_r;
    end
    upd = (in_mode == MODE_WALL) && win_ok && (in_side != SIDE_NONE) && ex[udir];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      heading_r  <= DIR_E;
      off_r      <= off_t'(HALF_UNITS);
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        row_r     <= row_nxt;
        col_r     <= col_nxt;
        heading_r <= heading_nxt;
        off_r     <= off_nxt;
      end
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row_r  <= row_nxt;
      s1_col_r  <= col_nxt;
      s1_head_r <= heading_nxt;
      s1_ex_r   <= ex;
      s1_addr_r <= ea;
      s1_upd_r  <= upd;
      s1_udir_r <= udir;
      s1_conf_r <= in_confidence;
    end
  end

  // wall stores: vertical edges hold east/west, horizontal edges south/north
  assign col_req.rd_en    = accept;
  assign col_req.rd_addr0 = ea[DIR_E];
  assign col_req.rd_addr1 = ea[DIR_W];
  assign col_req.wr_en    = s1_valid_r && s1_upd_r && !s1_udir_r[0];
  assign col_req.wr_addr  = s1_addr_r[s1_udir_r];
  assign col_req.wr_data  = new_val;

  assign row_req.rd_en    = accept;
  assign row_req.rd_addr0 = ea[DIR_S];
  assign row_req.rd_addr1 = ea[DIR_N];
  assign row_req.wr_en    = s1_valid_r && s1_upd_r && s1_udir_r[0];
  assign row_req.wr_addr  = s1_addr_r[s1_udir_r];
  assign row_req.wr_data  = new_val;

  mwm_wall_store u_col_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (col_req),
    .rd_data0 (col_q0),
    .rd_data1 (col_q1)
  );

  mwm_wall_store u_row_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (row_req),
    .rd_data0 (row_q0),
    .rd_data1 (row_q1)
  );

  always_comb begin
    ev[DIR_E] = col_q0;
    ev[DIR_W] = col_q1;
    ev[DIR_S] = row_q0;
    ev[DIR_N] = row_q1;
    ssum = {ev[s1_udir_r][WALL_W-1], ev[s1_udir_r]} + {s1_conf_r[WALL_W-1], s1_conf_r};
    priority if (ssum > 9'sd127) begin
      new_val = 8'sd127;
    end else if (ssum < -9'sd128) begin
      new_val = -8'sd128;
    end else begin
      new_val = wall_t'(ssum);
    end
    for (int d = 0; d < 4; d++) begin
      after[d] = (s1_upd_r && (s1_udir_r == dir_t'(d))) ? new_val : ev[d];
    end
    rdir = s1_head_r + 2'd1;
    ldir = s1_head_r + 2'd3;
    res.row        = 4'(s1_row_r);
    res.col        = 4'(s1_col_r);
    res.heading    = s1_head_r;
    res.open_right = s1_ex_r[rdir] && after[rdir][WALL_W-1];
    res.open_left  = s1_ex_r[ldir] && after[ldir][WALL_W-1];
    res.in_goal    = ((s1_row_r == row_t'(GOAL_ROW)) || (s1_row_r == row_t'(GOAL_ROW + 1)))
                  && ((s1_col_r == col_t'(GOAL_COL)) || (s1_col_r == col_t'(GOAL_COL + 1)));
  end

  // output buffer
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign occ       = cnt_r + {1'b0, s1_valid_r};
  assign in_ready  = rst_n && ((occ < 2'd2) || pop);
  assign cnt_nxt   = cnt_r + {1'b0, s1_valid_r} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (s1_valid_r) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      buf_r[wr_ptr_r] <= res;
    end
  end

  assign out_row        = buf_r[rd_ptr_r].row;
  assign out_col        = buf_r[rd_ptr_r].col;
  assign out_heading    = buf_r[rd_ptr_r].heading;
  assign out_open_right = buf_r[rd_ptr_r].open_right;
  assign out_open_left  = buf_r[rd_ptr_r].open_left;
  assign out_in_goal    = buf_r[rd_ptr_r].in_goal;

endmodule

// ===== sv/mwm_checker.sv =====
// ----------------------------------------------------------------------------
// mwm_port_checks
// Port-level checks of the maze wall map block, bound to the top level.
// ----------------------------------------------------------------------------
module mwm_port_checks (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] in_mode,
  input logic [1:0] in_new_heading,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_row,
  input logic [3:0] out_col,
  input logic [1:0] out_heading,
  input logic       out_open_right,
  input logic       out_open_left,
  input logic       out_in_goal
);
  import mwm_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(out_heading) && $stable(out_open_right) && $stable(out_open_left)
      && $stable(out_in_goal))
    else $error("stalled result changed");

  a_full_means_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_set_heading: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(in_valid && in_ready) && !out_valid && in_valid && in_ready
      && (in_mode == MODE_SET)
    |-> ##2 out_valid && (out_heading == $past(in_new_heading, 2)))
    else $error("set heading transaction gave wrong result");

endmodule

bind maze_wall_map_odometry mwm_port_checks u_mwm_port_checks (.*);
